@@ sv/cma_pkg.sv @@
// Shared types and constants for the confusion matrix accumulator.
`default_nettype none

package cma_pkg;

    // Matrix geometry and counter width
    localparam int MAX_CLASSES = 16;
    localparam int CLS_BITS    = $clog2(MAX_CLASSES);
    localparam int ADDR_BITS   = 2 * CLS_BITS;
    localparam int CELLS       = MAX_CLASSES * MAX_CLASSES;
    localparam int COUNT_BITS  = 32;
    localparam int CNT_W       = $clog2(MAX_CLASSES) + 1;

    // Q8.8 value of one half
    localparam logic signed [15:0] HALF_Q88 = 16'sd128;

    // Command queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    localparam logic REG_CLASS_COUNT = 1'b0;
    localparam logic REG_TARGET_MODE = 1'b1;

    // Input function codes
    typedef enum logic [1:0] {
        FUNC_ROW   = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    // Operations passed from the front end to the matrix engine
    typedef enum logic [1:0] {
        CMD_ROW   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t              op;
        logic [CLS_BITS-1:0]  true_cls;
        logic [CLS_BITS-1:0]  pred_cls;
        logic                 bad;
    } cmd_t;

endpackage

`default_nettype wire

@@ sv/cma_in_if.sv @@
// Input channel carrying score elements and matrix commands.
`default_nettype none

interface cma_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic signed [15:0] pred_score;
    logic signed [15:0] target_value;
    logic [3:0]  read_true_class;
    logic [3:0]  read_pred_class;

    modport source (
        output valid, func, pred_score, target_value, read_true_class, read_pred_class,
        input  ready
    );
    modport sink (
        input  valid, func, pred_score, target_value, read_true_class, read_pred_class,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/cma_out_if.sv @@
// Output channel carrying row results and cell reads.
`default_nettype none

interface cma_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] cell_count;
    logic [3:0]  row_pred_class;
    logic [3:0]  row_true_class;
    logic        row_done;
    logic        bad_target;

    modport source (
        output valid, cell_count, row_pred_class, row_true_class, row_done, bad_target,
        input  ready
    );
    modport sink (
        input  valid, cell_count, row_pred_class, row_true_class, row_done, bad_target,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/confusion_matrix_accumulator.sv @@
// Confusion matrix accumulator top level: config registers and part wiring.
//
// Usage: in_ch takes one item per transfer. func 0 is one column of a
// classifier row (pred_score, target_value); the last column of a row
// produces a result with row_done, the argmax and decoded true class, and
// bumps the matching 32-bit matrix cell (saturating). func 1 reads a cell
// and returns cell_count; func 2 clears the whole 16x16 matrix, no result.
// Configure class_count (address 0) and target_mode (address 4) over APB
// only while the block is idle.
// Throughput: one score column per cycle while in_ch.ready is high. A clear
// takes the matrix engine through fetch, then update; a row end or a read
// also loads the result register; the next command waits until it is transferred.
// Commands are buffered by a 4-entry queue; in_ch.ready drops only when that
// queue is full.
// A result passes from the queue through the command register and the result
// register before it is valid on out_ch.
// Reset clears the row state, the queue and the per-cell valid bits, so the
// matrix reads as zero at once with no clearing pass. If out_ch stalls, the
// result register holds, the engine waits and the queue fills, then in_ch stalls.
`default_nettype none

module confusion_matrix_accumulator (
    input  wire logic          clk,
    input  wire logic          rst_n,
    cma_in_if.sink             in_ch,
    cma_out_if.source          out_ch,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [4:0]          class_count_reg;
    logic                target_mode_reg;
    logic                cfg_write;
    logic                q_push, q_full, q_pop, q_valid;
    cma_pkg::cmd_t       q_in, q_out;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg <= 5'd2;
            target_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                cma_pkg::REG_CLASS_COUNT: class_count_reg <= pwdata[4:0];
                cma_pkg::REG_TARGET_MODE: target_mode_reg <= pwdata[0];
                default:                  target_mode_reg <= target_mode_reg;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (paddr[2])
            cma_pkg::REG_CLASS_COUNT: prdata = {27'd0, class_count_reg};
            cma_pkg::REG_TARGET_MODE: prdata = {31'd0, target_mode_reg};
            default:                  prdata = '0;
        endcase
    end

    cma_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .class_count (class_count_reg),
        .target_mode (target_mode_reg),
        .push        (q_push),
        .push_data   (q_in),
        .q_full      (q_full)
    );

    cma_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    cma_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_data  (q_out),
        .cmd_pop   (q_pop),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

@@ sv/cma_queue.sv @@
// Short command queue between the front end and the matrix engine.
`default_nettype none

module cma_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  cma_pkg::cmd_t      push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output cma_pkg::cmd_t      pop_data
);

    cma_pkg::cmd_t                  slot_reg [cma_pkg::QUEUE_DEPTH];
    logic [cma_pkg::QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [cma_pkg::QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [cma_pkg::QPTR_BITS:0]    count_reg, count_next;
    logic                           do_push, do_pop;

    assign full      = (count_reg == (cma_pkg::QPTR_BITS+1)'(cma_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (cma_pkg::QPTR_BITS+1)'(cma_pkg::QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

endmodule

`default_nettype wire

@@ sv/cma_front.sv @@
// Front end: running argmax, target decode and command issue.
`default_nettype none

module cma_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    cma_in_if.sink             in_ch,
    input  wire logic [4:0]    class_count,
    input  wire logic          target_mode,
    output logic               push,
    output cma_pkg::cmd_t      push_data,
    input  wire logic          q_full
);

    logic signed [15:0]            best_score_reg, best_score_next;
    logic [cma_pkg::CLS_BITS-1:0]  best_class_reg, best_class_next;
    logic [cma_pkg::CLS_BITS-1:0]  col_reg, col_next;
    logic [cma_pkg::CLS_BITS-1:0]  true_class_reg, true_class_next;
    logic                          true_found_reg, true_found_next;

    logic                          accept;
    logic [cma_pkg::CNT_W-1:0]     eff_n;
    logic                          row_end;
    logic                          bad;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;

    // Clamp class count to the supported range
    always_comb
    begin
        priority if (class_count < 5'd2)
        begin
            eff_n = cma_pkg::CNT_W'(2);
        end
        else if (class_count > 5'(cma_pkg::MAX_CLASSES))
        begin
            eff_n = cma_pkg::CNT_W'(cma_pkg::MAX_CLASSES);
        end
        else
        begin
            eff_n = cma_pkg::CNT_W'(class_count);
        end
    end

    assign row_end = ({1'b0, col_reg} + cma_pkg::CNT_W'(1)) >= eff_n;

    // Update row state and issue commands
    always_comb
    begin
        best_score_next = best_score_reg;
        best_class_next = best_class_reg;
        col_next        = col_reg;
        true_class_next = true_class_reg;
        true_found_next = true_found_reg;
        bad             = 1'b0;
        push            = 1'b0;
        push_data       = '{op: cma_pkg::CMD_READ,
                            true_cls: in_ch.read_true_class,
                            pred_cls: in_ch.read_pred_class,
                            bad: 1'b0};
        if (accept)
        begin
            unique case (in_ch.func)
                cma_pkg::FUNC_ROW:
                begin
                    // Restart at the first column, else track the first strict maximum
                    if (col_reg == '0)
                    begin
                        best_score_next = in_ch.pred_score;
                        best_class_next = '0;
                        true_class_next = '0;
                        true_found_next = 1'b0;
                    end
                    else if (in_ch.pred_score > best_score_reg)
                    begin
                        best_score_next = in_ch.pred_score;
                        best_class_next = col_reg;
                    end
                    // Decode the true class
                    if (!target_mode)
                    begin
                        if (!true_found_next && (in_ch.target_value > cma_pkg::HALF_Q88))
                        begin
                            true_class_next = col_reg;
                            true_found_next = 1'b1;
                        end
                    end
                    else if (col_reg == '0)
                    begin
                        if (!in_ch.target_value[15]
                            && (in_ch.target_value[14:0] < 15'(eff_n)))
                        begin
                            true_class_next = in_ch.target_value[cma_pkg::CLS_BITS-1:0];
                            true_found_next = 1'b1;
                        end
                    end
                    // Close the row and hand the cell update on
                    if (row_end)
                    begin
                        col_next = '0;
                        if (!true_found_next)
                        begin
                            bad             = target_mode;
                            true_class_next = '0;
                        end
                        push      = 1'b1;
                        push_data = '{op: cma_pkg::CMD_ROW,
                                      true_cls: true_class_next,
                                      pred_cls: best_class_next,
                                      bad: bad};
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
                cma_pkg::FUNC_READ:
                begin
                    push = 1'b1;
                end
                cma_pkg::FUNC_CLEAR:
                begin
                    push           = 1'b1;
                    push_data.op   = cma_pkg::CMD_CLEAR;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_score_reg <= '0;
            best_class_reg <= '0;
            col_reg        <= '0;
            true_class_reg <= '0;
            true_found_reg <= 1'b0;
        end
        else
        begin
            best_score_reg <= best_score_next;
            best_class_reg <= best_class_next;
            col_reg        <= col_next;
            true_class_reg <= true_class_next;
            true_found_reg <= true_found_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_data.op == cma_pkg::CMD_ROW) |=> (col_reg == '0))
        else $error("column index not restarted after row end");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_data.bad) |-> (target_mode && push_data.op == cma_pkg::CMD_ROW))
        else $error("bad target flagged outside index mode row end");

endmodule

`default_nettype wire

@@ sv/cma_back.sv @@
// Back end: matrix store with read-modify-write, reads, clears and result register.
`default_nettype none

module cma_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  cma_pkg::cmd_t      cmd_data,
    output logic               cmd_pop,
    cma_out_if.source          out_ch
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    localparam logic [cma_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

    state_t                           state_reg, state_next;
    cma_pkg::cmd_t                    cmd_reg;
    logic [cma_pkg::COUNT_BITS-1:0]   mem [cma_pkg::CELLS];
    logic [cma_pkg::CELLS-1:0]        vld_reg;
    logic [cma_pkg::COUNT_BITS-1:0]   rd_data_reg;
    logic                             rd_vld_reg;
    logic [cma_pkg::ADDR_BITS-1:0]    rd_addr, wr_addr;
    logic [cma_pkg::COUNT_BITS-1:0]   cur_count, inc_count;
    logic                             do_write, do_clear;

    logic                             out_valid_reg, out_valid_next;
    logic [31:0]                      out_count_reg, out_count_next;
    logic [3:0]                       out_pred_reg, out_pred_next;
    logic [3:0]                       out_true_reg, out_true_next;
    logic                             out_done_reg, out_done_next;
    logic                             out_bad_reg, out_bad_next;

    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_valid && !out_valid_reg;
    assign rd_addr   = {cmd_data.true_cls, cmd_data.pred_cls};
    assign wr_addr   = {cmd_reg.true_cls, cmd_reg.pred_cls};
    assign cur_count = rd_vld_reg ? rd_data_reg : '0;
    assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
    assign do_write  = (state_reg == ST_EXEC) && (cmd_reg.op == cma_pkg::CMD_ROW)
                       && !cmd_reg.bad;
    assign do_clear  = (state_reg == ST_EXEC) && (cmd_reg.op == cma_pkg::CMD_CLEAR);

    // Sequence one command: fetch the cell, then execute
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        out_pred_next  = out_pred_reg;
        out_true_next  = out_true_reg;
        out_done_next  = out_done_reg;
        out_bad_next   = out_bad_reg;
        if (out_ch.valid && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_pop)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                unique case (cmd_reg.op)
                    cma_pkg::CMD_ROW:
                    begin
                        out_valid_next = 1'b1;
                        out_count_next = '0;
                        out_pred_next  = 4'(cmd_reg.pred_cls);
                        out_true_next  = cmd_reg.bad ? 4'd0 : 4'(cmd_reg.true_cls);
                        out_done_next  = 1'b1;
                        out_bad_next   = cmd_reg.bad;
                    end
                    cma_pkg::CMD_READ:
                    begin
                        out_valid_next = 1'b1;
                        out_count_next = cur_count[31:0];
                        out_pred_next  = '0;
                        out_true_next  = '0;
                        out_done_next  = 1'b0;
                        out_bad_next   = 1'b0;
                    end
                    default:
                    begin
                        out_valid_next = out_valid_next;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (do_clear)
            begin
                vld_reg <= '0;
            end
            else if (do_write)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Hold command and result payload
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd_data;
        end
        out_count_reg <= out_count_next;
        out_pred_reg  <= out_pred_next;
        out_true_reg  <= out_true_next;
        out_done_reg  <= out_done_next;
        out_bad_reg   <= out_bad_next;
    end

    // Matrix store: registered read, single write port
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[wr_addr] <= inc_count;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.cell_count     = out_count_reg;
    assign out_ch.row_pred_class = out_pred_reg;
    assign out_ch.row_true_class = out_true_reg;
    assign out_ch.row_done       = out_done_reg;
    assign out_ch.bad_target     = out_bad_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg == ST_EXEC))
        else $error("command taken without execute cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        do_clear |=> (vld_reg == '0))
        else $error("matrix not cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> !out_valid_reg)
        else $error("execute started with a result still pending");

endmodule

`default_nettype wire

@@ bench/tb_confusion_matrix_accumulator.sv @@
// Testbench for the confusion matrix accumulator: directed table, then random rows against a tally predictor.
module tb_confusion_matrix_accumulator;

    localparam logic [1:0] FUNC_UNUSED      = 2'd3;
    localparam logic [2:0] ADDR_CLASS_COUNT = {cma_pkg::REG_CLASS_COUNT, 2'b00};
    localparam logic [2:0] ADDR_TARGET_MODE = {cma_pkg::REG_TARGET_MODE, 2'b00};
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 120;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 65;
    localparam int BURST_ITEMS   = 40;
    localparam int MAX_PRINTS    = 50;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] pred_score;
        logic signed [15:0] target_value;
        logic [3:0]         read_true;
        logic [3:0]         read_pred;
    } score_item_t;

    typedef struct packed {
        logic [31:0] cell_count;
        logic [3:0]  pred_cls;
        logic [3:0]  true_cls;
        logic        row_done;
        logic        bad_target;
    } tally_t;

    typedef enum logic {
        STEP_ITEM,
        STEP_CFG
    } step_kind_t;

    typedef struct packed {
        step_kind_t  kind;
        score_item_t item;
        logic        literal;
        tally_t      want;
        logic [2:0]  addr;
        logic [31:0] data;
    } step_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cma_in_if  in_ch ();
    cma_out_if out_ch ();

    confusion_matrix_accumulator u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // Predictor copy of the registers and the matrix state
    logic [4:0]  class_count_reg = 5'd2;
    logic        mode_reg        = 1'b0;
    logic [31:0] hits [cma_pkg::CELLS] = '{default: '0};
    int          row_col         = 0;
    int          best_score      = 0;
    int          best_cls        = 0;
    int          true_cls_st     = 0;
    bit          true_seen       = 1'b0;

    tally_t      due_results [$];
    int          mismatch_cnt    = 0;

    // Offered alongside each item: a literal expectation that overrides the predictor
    logic        item_has_literal;
    tally_t      item_literal;

    int          send_idle_pct   = 0;
    int          recv_idle_pct;
    logic        hold_req;

    function automatic int eff_classes();
        if (class_count_reg < 5'd2)
            return 2;
        if (class_count_reg > cma_pkg::MAX_CLASSES)
            return cma_pkg::MAX_CLASSES;
        return int'(class_count_reg);
    endfunction

    // Advance the row state for one item; return 1 with the result it causes
    function automatic bit score_and_tally(input score_item_t it, output tally_t res);
        int n;
        int ps;
        int tv;
        bit bad;
        logic [7:0] hit_idx;
        n   = eff_classes();
        ps  = $signed(it.pred_score);
        tv  = $signed(it.target_value);
        bad = 1'b0;
        res = '0;
        case (it.func)
            cma_pkg::FUNC_READ:
            begin
                res.cell_count = hits[{it.read_true, it.read_pred}];
                return 1'b1;
            end
            cma_pkg::FUNC_CLEAR:
            begin
                foreach (hits[i])
                    hits[i] = '0;
                return 1'b0;
            end
            cma_pkg::FUNC_ROW:
            begin
                // Track the first strict maximum
                if (row_col == 0)
                begin
                    best_score  = ps;
                    best_cls    = 0;
                    true_cls_st = 0;
                    true_seen   = 1'b0;
                end
                else if (ps > best_score)
                begin
                    best_score = ps;
                    best_cls   = row_col;
                end
                // Decode the true class
                if (mode_reg == 1'b0)
                begin
                    if (!true_seen && tv > int'(cma_pkg::HALF_Q88))
                    begin
                        true_cls_st = row_col;
                        true_seen   = 1'b1;
                    end
                end
                else if (row_col == 0 && tv >= 0 && tv < n)
                begin
                    true_cls_st = tv;
                    true_seen   = 1'b1;
                end
                if (row_col + 1 < n)
                begin
                    row_col++;
                    return 1'b0;
                end
                // Close the row and bump the cell, saturating
                row_col = 0;
                if (!true_seen)
                begin
                    if (mode_reg)
                        bad = 1'b1;
                    else
                        true_cls_st = 0;
                end
                if (!bad)
                begin
                    hit_idx = {4'(true_cls_st), 4'(best_cls)};
                    if (hits[hit_idx] != '1)
                        hits[hit_idx] = hits[hit_idx] + 32'd1;
                end
                res.pred_cls   = 4'(best_cls);
                res.true_cls   = bad ? 4'd0 : 4'(true_cls_st);
                res.row_done   = 1'b1;
                res.bad_target = bad;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_PRINTS)
            $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // Check each result transfer and predict each item transfer
    always @(posedge clk)
    begin
        tally_t      got;
        tally_t      calc;
        score_item_t seen;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.cell_count = out_ch.cell_count;
                got.pred_cls   = out_ch.row_pred_class;
                got.true_cls   = out_ch.row_true_class;
                got.row_done   = out_ch.row_done;
                got.bad_target = out_ch.bad_target;
                if (due_results.size() == 0)
                    flag_mismatch("unexpected result", got.cell_count, '0);
                else
                begin
                    calc = due_results.pop_front();
                    if (got.cell_count !== calc.cell_count)
                        flag_mismatch("cell_count", got.cell_count, calc.cell_count);
                    if (got.pred_cls !== calc.pred_cls)
                        flag_mismatch("row_pred_class", 32'(got.pred_cls),
                                      32'(calc.pred_cls));
                    if (got.true_cls !== calc.true_cls)
                        flag_mismatch("row_true_class", 32'(got.true_cls),
                                      32'(calc.true_cls));
                    if (got.row_done !== calc.row_done)
                        flag_mismatch("row_done", 32'(got.row_done), 32'(calc.row_done));
                    if (got.bad_target !== calc.bad_target)
                        flag_mismatch("bad_target", 32'(got.bad_target),
                                      32'(calc.bad_target));
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                seen = {in_ch.func, in_ch.pred_score, in_ch.target_value,
                        in_ch.read_true_class, in_ch.read_pred_class};
                if (score_and_tally(seen, calc))
                    due_results.push_back(item_has_literal ? item_literal : calc);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on each request toggle
    initial
    begin
        logic hold_ack;
        int   hold_left;
        hold_ack  = 1'b0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req !== hold_ack)
            begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one item after random idle cycles; return at its transfer edge
    task automatic offer(input score_item_t it, input logic literal, input tally_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.func            <= it.func;
        in_ch.pred_score      <= it.pred_score;
        in_ch.target_value    <= it.target_value;
        in_ch.read_true_class <= it.read_true;
        in_ch.read_pred_class <= it.read_pred;
        item_has_literal      <= literal;
        item_literal          <= want;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
    endtask

    // Stop offering and hold until every result is in and the engine is quiet
    task automatic wait_settled();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_CLASS_COUNT)
            class_count_reg = data[4:0];
        else if (addr == ADDR_TARGET_MODE)
            mode_reg = data[0];
    endtask

    // Mostly row elements with targets that decode, some reads, rare clears and junk
    function automatic score_item_t rand_item();
        score_item_t it;
        int unsigned pick;
        int          n;
        n    = eff_classes();
        pick = $urandom_range(99);
        if (pick < 82)
            it.func = cma_pkg::FUNC_ROW;
        else if (pick < 94)
            it.func = cma_pkg::FUNC_READ;
        else if (pick < 97)
            it.func = cma_pkg::FUNC_CLEAR;
        else
            it.func = FUNC_UNUSED;
        if ($urandom_range(3) == 0)
            it.pred_score = 16'($urandom_range(4)) - 16'sd2;
        else
            it.pred_score = 16'($urandom);
        pick = $urandom_range(9);
        if (mode_reg == 1'b0)
        begin
            if (pick < 5)
                it.target_value = '0;
            else if (pick < 7)
                it.target_value = 16'sd256;
            else if (pick == 7)
                it.target_value = cma_pkg::HALF_Q88 + 16'($urandom_range(1));
            else if (pick == 8)
                it.target_value = 16'($urandom);
            else
                it.target_value = -16'sd256;
        end
        else
        begin
            if (pick < 8)
                it.target_value = 16'($urandom_range(n - 1));
            else if (pick == 8)
                it.target_value = 16'(n);
            else
                it.target_value = 16'($urandom);
        end
        it.read_true = $urandom_range(1) ? 4'($urandom_range(n - 1)) : 4'($urandom_range(15));
        it.read_pred = $urandom_range(1) ? 4'($urandom_range(n - 1)) : 4'($urandom_range(15));
        return it;
    endfunction

    // Directed table builders
    function automatic step_t el(input int ps, input int tv);
        step_t s;
        s = '0;
        s.kind              = STEP_ITEM;
        s.item.func         = cma_pkg::FUNC_ROW;
        s.item.pred_score   = 16'(ps);
        s.item.target_value = 16'(tv);
        return s;
    endfunction

    function automatic step_t el_end(input int ps, input int tv, input int pred,
                                     input int tru, input logic bad);
        step_t s;
        s = el(ps, tv);
        s.literal         = 1'b1;
        s.want.pred_cls   = 4'(pred);
        s.want.true_cls   = 4'(tru);
        s.want.row_done   = 1'b1;
        s.want.bad_target = bad;
        return s;
    endfunction

    function automatic step_t rd(input int t, input int p, input int cnt);
        step_t s;
        s = '0;
        s.kind            = STEP_ITEM;
        s.item.func       = cma_pkg::FUNC_READ;
        s.item.read_true  = 4'(t);
        s.item.read_pred  = 4'(p);
        s.literal         = 1'b1;
        s.want.cell_count = 32'(cnt);
        return s;
    endfunction

    function automatic step_t cmd(input logic [1:0] f);
        step_t s;
        s = '0;
        s.kind      = STEP_ITEM;
        s.item.func = f;
        return s;
    endfunction

    function automatic step_t cfg(input logic [2:0] addr, input logic [31:0] data);
        step_t s;
        s = '0;
        s.kind = STEP_CFG;
        s.addr = addr;
        s.data = data;
        return s;
    endfunction

    initial
    begin
        step_t dir [$];
        int    phase_counts [PHASES];
        phase_counts = '{2, 16, 31, 0, 7, 1, 17, 3, 12};

        rst_n                 <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.func            <= cma_pkg::FUNC_ROW;
        in_ch.pred_score      <= '0;
        in_ch.target_value    <= '0;
        in_ch.read_true_class <= '0;
        in_ch.read_pred_class <= '0;
        item_has_literal      <= 1'b0;
        item_literal          <= '0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        hold_req              <= 1'b0;
        recv_idle_pct         <= 50;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty after reset, both corners
        dir.push_back(rd(0, 0, 0));
        dir.push_back(rd(15, 15, 0));
        // Score extremes; one-hot threshold is strictly above one half
        dir.push_back(el(32767, -32768));
        dir.push_back(el_end(-32768, 32767, 0, 1, 1'b0));
        dir.push_back(el(-32768, 128));
        dir.push_back(el_end(-32768, 129, 0, 1, 1'b0));
        // No hot column defaults to class zero
        dir.push_back(el(5, 0));
        dir.push_back(el_end(6, -1, 1, 0, 1'b0));
        dir.push_back(rd(1, 0, 2));
        dir.push_back(rd(0, 1, 1));
        // Clear wipes the store; the unused code does nothing
        dir.push_back(cmd(cma_pkg::FUNC_CLEAR));
        dir.push_back(rd(1, 0, 0));
        dir.push_back(cmd(FUNC_UNUSED));
        // Index mode: valid index, then negative, too large and most negative
        dir.push_back(cfg(ADDR_TARGET_MODE, 32'd1));
        dir.push_back(el(0, 1));
        dir.push_back(el_end(1, 0, 1, 1, 1'b0));
        dir.push_back(el(0, -1));
        dir.push_back(el_end(-5, 0, 0, 0, 1'b1));
        dir.push_back(el(-1, 2));
        dir.push_back(el_end(0, 0, 1, 0, 1'b1));
        dir.push_back(el(0, -32768));
        dir.push_back(el_end(0, 32767, 0, 0, 1'b1));
        // Class count below range clamps to two
        dir.push_back(cfg(ADDR_CLASS_COUNT, 32'd0));
        dir.push_back(el(0, 0));
        dir.push_back(el_end(-1, 1, 0, 0, 1'b0));
        // Shrink the class count in the middle of a row
        dir.push_back(cfg(ADDR_CLASS_COUNT, 32'd3));
        dir.push_back(cfg(ADDR_TARGET_MODE, 32'd0));
        dir.push_back(el(0, 0));
        dir.push_back(el(1, 200));
        dir.push_back(cfg(ADDR_CLASS_COUNT, 32'd2));
        dir.push_back(el_end(300, 0, 2, 1, 1'b0));
        dir.push_back(rd(1, 2, 1));

        foreach (dir[i])
        begin
            if (dir[i].kind == STEP_CFG)
            begin
                wait_settled();
                reg_write(dir[i].addr, dir[i].data);
            end
            else
                offer(dir[i].item, dir[i].literal, dir[i].want);
        end

        // Random phases: idle mix moves from receiver to sender, then none
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_settled();
            if (ph == 6)
            begin
                // Stall the receiver while items keep coming, then drain
                reg_write(ADDR_CLASS_COUNT, 32'd2);
                reg_write(ADDR_TARGET_MODE, 32'd0);
                send_idle_pct = 0;
                hold_req <= ~hold_req;
                for (int k = 0; k < BURST_ITEMS; k++)
                    offer(rand_item(), 1'b0, '0);
                wait_settled();
            end
            reg_write(ADDR_CLASS_COUNT, 32'(phase_counts[ph]));
            reg_write(ADDR_TARGET_MODE, 32'(ph % 2));
            if (ph < 3)
            begin
                send_idle_pct = 9;
                recv_idle_pct <= 82;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 82;
                recv_idle_pct <= 9;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
                offer(rand_item(), 1'b0, '0);
        end

        wait_settled();
        if (mismatch_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
